/* sv/wtls_pkg.sv */
package wtls_pkg;

  localparam int FRAC_BITS = 16;

  localparam int WORD_W   = 32;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int SQ_IN_W  = WORD_W + FRAC_BITS;
  localparam int SQRT_W   = (SQ_IN_W + 1) / 2;
  localparam int SQ_PAD_W = 2 * SQRT_W;
  localparam int SQ_REM_W = SQRT_W + 2;
  localparam int BU_W     = PROD_W - FRAC_BITS;
  localparam int MAG_W    = BU_W + 2;
  localparam int P_W      = MAG_W + WORD_W;
  localparam int DQ_W     = WORD_W + 1;
  localparam int D_W      = DQ_W + 1;
  localparam int ITER_MAX = (SQRT_W > DQ_W) ? SQRT_W : DQ_W;
  localparam int CNT_W    = $clog2(ITER_MAX);

  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE_AREA   = 3'd0,
    REG_DRAIN_FLOW  = 3'd1,
    REG_INFLOW_GAIN = 3'd2,
    REG_PIPE_COEF   = 3'd3,
    REG_TIME_STEP   = 3'd4,
    REG_START_LEVEL = 3'd5
  } cfg_reg_e;

  localparam logic [WORD_W-1:0] BASE_AREA_RST   = 32'd65536;
  localparam logic [WORD_W-1:0] DRAIN_FLOW_RST  = 32'd0;
  localparam logic [WORD_W-1:0] INFLOW_GAIN_RST = 32'd65536;
  localparam logic [WORD_W-1:0] PIPE_COEF_RST   = 32'd65536;
  localparam logic [WORD_W-1:0] TIME_STEP_RST   = 32'd6554;
  localparam logic [WORD_W-1:0] START_LEVEL_RST = 32'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_U,
    ST_SQRT,
    ST_MUL_A,
    ST_SUM,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV_CHK,
    ST_DIV,
    ST_UPDATE
  } state_e;

endpackage

/* sv/water_tank_level_step_core.sv */
// Steps with valid parameters: 24-bit square root, a shared 32x32 multiplier used four times,
//   and a divide with a 33-bit quotient; the divide is skipped when the change saturates,
//   and every step is skipped with invalid parameters.
// Input is taken only while the sequencer is idle; a finished result may wait in the output register.
// Reset (rst_ni low, asynchronous): level cleared, registers at their defaults.
module water_tank_level_step_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wtls_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [wtls_pkg::WORD_W-1:0]           cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [31:0]                           s_axis_tdata,  // [31:0] inflow_control
  input  logic [0:0]                            s_axis_tuser,  // [0] restart
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [31:0]                           m_axis_tdata,  // [31:0] new_level
  output logic [0:0]                            m_axis_tuser   // [0] param_error
);

  localparam int W    = wtls_pkg::WORD_W;
  localparam int FB   = wtls_pkg::FRAC_BITS;
  localparam int SQW  = wtls_pkg::SQRT_W;
  localparam int SPW  = wtls_pkg::SQ_PAD_W;
  localparam int SRW  = wtls_pkg::SQ_REM_W;
  localparam int BUW  = wtls_pkg::BU_W;
  localparam int MW   = wtls_pkg::MAG_W;
  localparam int PW   = wtls_pkg::P_W;
  localparam int DQW  = wtls_pkg::DQ_W;
  localparam int DW   = wtls_pkg::D_W;
  localparam int CW   = wtls_pkg::CNT_W;
  localparam int PRW  = wtls_pkg::PROD_W;

  wtls_pkg::state_e state_q, state_d;

  logic [W-1:0] base_area_q, drain_flow_q, inflow_gain_q, pipe_coef_q;
  logic [W-1:0] time_step_q, start_level_q;

  logic [W-1:0]     level_q;
  logic [W-1:0]     umag_q;
  logic             uneg_q;
  logic             err_q;
  logic [SPW-1:0]   sq_v_q;
  logic [SRW-1:0]   sq_rem_q;
  logic [SQW-1:0]   sq_root_q;
  logic [CW-1:0]    cnt_q;
  logic [PRW-1:0]   prod_q;
  logic [BUW-1:0]   bu_q;
  logic [MW-1:0]    neg_q;
  logic [MW-1:0]    mag_q;
  logic             rneg_q;
  logic [PRW-1:0]   acc_q;
  logic [PW-1:0]    p_q;
  logic [W-1:0]     drem_q;
  logic [DQW-1:0]   quo_q;
  logic             sat_q;
  logic             out_valid_q;
  logic [W-1:0]     out_level_q;
  logic             out_err_q;

  logic             in_fire;
  logic             param_bad;
  logic [W-1:0]     lvl_in;
  logic [W-1:0]     umag_in;
  logic             mul_en;
  logic [W-1:0]     mul_a, mul_b;
  logic             out_free;
  logic             sqrt_last, div_last, div_sat;

  logic [SRW-1:0]   sq_rem_sh;
  logic [SRW-1:0]   sq_trial;
  logic             sq_take;

  logic [DQW-1:0]   drem_sh;
  logic             d_take;

  logic [BUW-1:0]   pos_val;
  logic [DW-1:0]    dval;
  logic [DW+1:0]    up_sum;
  logic [W-1:0]     up_level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_area_q   <= wtls_pkg::BASE_AREA_RST;
      drain_flow_q  <= wtls_pkg::DRAIN_FLOW_RST;
      inflow_gain_q <= wtls_pkg::INFLOW_GAIN_RST;
      pipe_coef_q   <= wtls_pkg::PIPE_COEF_RST;
      time_step_q   <= wtls_pkg::TIME_STEP_RST;
      start_level_q <= wtls_pkg::START_LEVEL_RST;
    end else if (cfg_valid_i) begin
      unique case (wtls_pkg::cfg_reg_e'(cfg_addr_i))
        wtls_pkg::REG_BASE_AREA:   base_area_q   <= cfg_data_i;
        wtls_pkg::REG_DRAIN_FLOW:  drain_flow_q  <= cfg_data_i;
        wtls_pkg::REG_INFLOW_GAIN: inflow_gain_q <= cfg_data_i;
        wtls_pkg::REG_PIPE_COEF:   pipe_coef_q   <= cfg_data_i;
        wtls_pkg::REG_TIME_STEP:   time_step_q   <= cfg_data_i;
        wtls_pkg::REG_START_LEVEL: start_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign param_bad = (base_area_q == '0) || (inflow_gain_q == '0) || (pipe_coef_q == '0);
  assign lvl_in    = s_axis_tuser[0] ? start_level_q : level_q;
  assign umag_in   = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign sqrt_last = (cnt_q == CW'(SQW - 1));
  assign div_last  = (cnt_q == CW'(DQW - 1));
  assign div_sat   = (p_q[PW-1:DQW] >= (PW-DQW)'(base_area_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wtls_pkg::ST_IDLE: begin
        if (in_fire) state_d = param_bad ? wtls_pkg::ST_UPDATE : wtls_pkg::ST_MUL_U;
      end
      wtls_pkg::ST_MUL_U:    state_d = wtls_pkg::ST_SQRT;
      wtls_pkg::ST_SQRT: begin
        if (sqrt_last) state_d = wtls_pkg::ST_MUL_A;
      end
      wtls_pkg::ST_MUL_A:    state_d = wtls_pkg::ST_SUM;
      wtls_pkg::ST_SUM:      state_d = wtls_pkg::ST_DIFF;
      wtls_pkg::ST_DIFF:     state_d = wtls_pkg::ST_MUL_LO;
      wtls_pkg::ST_MUL_LO:   state_d = wtls_pkg::ST_MUL_HI;
      wtls_pkg::ST_MUL_HI:   state_d = wtls_pkg::ST_DIV_INIT;
      wtls_pkg::ST_DIV_INIT: state_d = wtls_pkg::ST_DIV_CHK;
      wtls_pkg::ST_DIV_CHK:  state_d = div_sat ? wtls_pkg::ST_UPDATE : wtls_pkg::ST_DIV;
      wtls_pkg::ST_DIV: begin
        if (div_last) state_d = wtls_pkg::ST_UPDATE;
      end
      wtls_pkg::ST_UPDATE: begin
        if (out_free) state_d = wtls_pkg::ST_IDLE;
      end
      default: state_d = wtls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      wtls_pkg::ST_IDLE: s_axis_tready = 1'b1;
      wtls_pkg::ST_MUL_U: begin
        mul_en = 1'b1;
        mul_a  = umag_q;
        mul_b  = inflow_gain_q;
      end
      wtls_pkg::ST_MUL_A: begin
        mul_en = 1'b1;
        mul_a  = W'(sq_root_q);
        mul_b  = pipe_coef_q;
      end
      wtls_pkg::ST_MUL_LO: begin
        mul_en = 1'b1;
        mul_a  = mag_q[W-1:0];
        mul_b  = time_step_q;
      end
      wtls_pkg::ST_MUL_HI: begin
        mul_en = 1'b1;
        mul_a  = W'(mag_q[MW-1:W]);
        mul_b  = time_step_q;
      end
      default: ;
    endcase
  end

  assign sq_rem_sh = {sq_rem_q[SRW-3:0], sq_v_q[SPW-1:SPW-2]};
  assign sq_trial  = {sq_root_q, 2'b01};
  assign sq_take   = (sq_rem_sh >= sq_trial);

  assign drem_sh = {drem_q, quo_q[DQW-1]};
  assign d_take  = (drem_sh >= DQW'(base_area_q));

  assign pos_val  = uneg_q ? '0 : bu_q;
  assign dval     = sat_q ? (DW'(1) << DQW) : DW'(quo_q);
  assign up_sum   = (DW+2)'(level_q) + (DW+2)'(dval);

  always_comb begin
    if (rneg_q) begin
      up_level = (dval >= DW'(level_q)) ? '0 : (level_q - dval[W-1:0]);
    end else begin
      up_level = (up_sum[DW+1:W] != '0) ? '1 : up_sum[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wtls_pkg::ST_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) level_q <= lvl_in;
      if (state_q == wtls_pkg::ST_UPDATE && out_free) begin
        if (!err_q) level_q <= up_level;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == wtls_pkg::ST_SQRT || state_q == wtls_pkg::ST_DIV) begin
        cnt_q <= (sqrt_last && state_q == wtls_pkg::ST_SQRT) ? '0 : cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      uneg_q    <= s_axis_tdata[31];
      umag_q    <= umag_in;
      err_q     <= param_bad;
      sq_v_q    <= SPW'({lvl_in, {FB{1'b0}}});
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end
    if (mul_en) prod_q <= PRW'(mul_a) * PRW'(mul_b);
    unique case (state_q)
      wtls_pkg::ST_SQRT: begin
        sq_v_q    <= {sq_v_q[SPW-3:0], 2'b00};
        sq_rem_q  <= sq_take ? (sq_rem_sh - sq_trial) : sq_rem_sh;
        sq_root_q <= {sq_root_q[SQW-2:0], sq_take};
      end
      wtls_pkg::ST_MUL_A: bu_q <= prod_q[PRW-1:FB];
      wtls_pkg::ST_SUM: begin
        neg_q <= MW'(uneg_q ? bu_q : '0) + MW'(prod_q[PRW-1:FB]) + MW'(drain_flow_q);
      end
      wtls_pkg::ST_DIFF: begin
        rneg_q <= (neg_q > MW'(pos_val));
        mag_q  <= (neg_q > MW'(pos_val)) ? (neg_q - MW'(pos_val)) : (MW'(pos_val) - neg_q);
      end
      wtls_pkg::ST_MUL_HI: acc_q <= prod_q;
      wtls_pkg::ST_DIV_INIT: p_q <= {prod_q[MW-1:0], {W{1'b0}}} + PW'(acc_q);
      wtls_pkg::ST_DIV_CHK: begin
        sat_q  <= div_sat;
        drem_q <= p_q[W+DQW-1:DQW];
        quo_q  <= p_q[DQW-1:0];
      end
      wtls_pkg::ST_DIV: begin
        drem_q <= d_take ? W'(drem_sh - DQW'(base_area_q)) : drem_sh[W-1:0];
        quo_q  <= {quo_q[DQW-2:0], d_take};
      end
      wtls_pkg::ST_UPDATE: begin
        if (out_free) begin
          out_level_q <= err_q ? level_q : up_level;
          out_err_q   <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_level_q;
  assign m_axis_tuser  = out_err_q;

endmodule

/* sv/wtls_checker.sv */
module wtls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic       in_fire, out_fire;
  logic [1:0] pend_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input ready right after an input transaction");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after its input transaction");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pend_q != 2'd0) && (pend_q != 2'd3))
    else $error("result without a matching input transaction");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind water_tank_level_step_core wtls_checker u_wtls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/water_tank_level_step_core_tb.sv */
module water_tank_level_step_core_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS  = 125;
  localparam logic [wtls_pkg::CFG_ADDR_W-1:0] ADDR_SPARE_LO = 3'd6;
  localparam logic [wtls_pkg::CFG_ADDR_W-1:0] ADDR_SPARE_HI = 3'd7;

  typedef enum int {
    PROF_PLANT,
    PROF_FULL_RANGE,
    PROF_EXTREME,
    PROF_BAD_PARAM
  } cfg_profile_e;

  typedef struct packed {
    logic [wtls_pkg::WORD_W-1:0] level;
    logic                        param_error;
  } tank_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [wtls_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [wtls_pkg::WORD_W-1:0]     cfg_data_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata = '0;
  logic [0:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b1;
  logic [31:0]                     m_axis_tdata;
  logic [0:0]                      m_axis_tuser;

  logic [wtls_pkg::WORD_W-1:0] cfg_area  = wtls_pkg::BASE_AREA_RST;
  logic [wtls_pkg::WORD_W-1:0] cfg_drain = wtls_pkg::DRAIN_FLOW_RST;
  logic [wtls_pkg::WORD_W-1:0] cfg_gain  = wtls_pkg::INFLOW_GAIN_RST;
  logic [wtls_pkg::WORD_W-1:0] cfg_pipe  = wtls_pkg::PIPE_COEF_RST;
  logic [wtls_pkg::WORD_W-1:0] cfg_dt    = wtls_pkg::TIME_STEP_RST;
  logic [wtls_pkg::WORD_W-1:0] cfg_start = wtls_pkg::START_LEVEL_RST;
  logic [wtls_pkg::WORD_W-1:0] tank_level = '0;

  tank_result_t expected_levels[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  stall_pct = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b0;
  int  burst_left = 0;

  water_tank_level_step_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic tank_result_t step_level(input logic [31:0] u, input logic restart);
    logic [63:0]  u_mag;
    logic [63:0]  inflow;
    logic [63:0]  outflow;
    logic [63:0]  root;
    logic [63:0]  rate_mag;
    logic [127:0] change;
    logic [127:0] total;
    logic         draining;
    tank_result_t res;
    if (restart) tank_level = cfg_start;
    if (cfg_area == '0 || cfg_gain == '0 || cfg_pipe == '0) begin
      res.level = tank_level;
      res.param_error = 1'b1;
      return res;
    end
    u_mag = u[31] ? (64'd1 << 32) - 64'(u) : 64'(u);
    inflow = '0;
    outflow = '0;
    if (u[31]) outflow = (u_mag * 64'(cfg_gain)) >> wtls_pkg::FRAC_BITS;
    else inflow = (u_mag * 64'(cfg_gain)) >> wtls_pkg::FRAC_BITS;
    root = 64'(floor_sqrt(64'(tank_level) << wtls_pkg::FRAC_BITS));
    outflow += (root * 64'(cfg_pipe)) >> wtls_pkg::FRAC_BITS;
    outflow += 64'(cfg_drain);
    draining = outflow > inflow;
    rate_mag = draining ? outflow - inflow : inflow - outflow;
    change = (128'(rate_mag) * 128'(cfg_dt)) / 128'(cfg_area);
    if (change > (128'd1 << 33)) change = 128'd1 << 33;
    if (draining) begin
      tank_level = (change >= 128'(tank_level)) ? '0 : tank_level - change[31:0];
    end else begin
      total = 128'(tank_level) + change;
      tank_level = (total > 128'hFFFF_FFFF) ? '1 : total[31:0];
    end
    res.level = tank_level;
    res.param_error = 1'b0;
    return res;
  endfunction

  function automatic logic [31:0] pick_inflow();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      4, 5, 6:    return $urandom;
      7: begin
        case ($urandom_range(3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default:    return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 32'd1;
      1:       return '1;
      2:       return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // hold tready low for random stretches
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tank_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual level %h error %b",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = expected_levels.pop_front();
        if (m_axis_tdata !== want.level) begin
          $display("%0t: new_level mismatch: expected %h, actual %h",
                   $time, want.level, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.param_error) begin
          $display("%0t: param_error mismatch: expected %b, actual %b",
                   $time, want.param_error, m_axis_tuser[0]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [wtls_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [wtls_pkg::WORD_W-1:0] value);
    cfg_addr_i <= addr;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      wtls_pkg::REG_BASE_AREA:   cfg_area = value;
      wtls_pkg::REG_DRAIN_FLOW:  cfg_drain = value;
      wtls_pkg::REG_INFLOW_GAIN: cfg_gain = value;
      wtls_pkg::REG_PIPE_COEF:   cfg_pipe = value;
      wtls_pkg::REG_TIME_STEP:   cfg_dt = value;
      wtls_pkg::REG_START_LEVEL: cfg_start = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [31:0] u, input logic restart);
    s_axis_tdata <= u;
    s_axis_tuser <= restart;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_levels.push_back(step_level(u, restart));
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_default_registers();
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    wait_idle();
  endtask

  task automatic test_invalid_parameters();
    write_reg(wtls_pkg::REG_START_LEVEL, 32'h0012_3456);
    write_reg(wtls_pkg::REG_BASE_AREA, '0);
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    wait_idle();
    write_reg(wtls_pkg::REG_BASE_AREA, wtls_pkg::BASE_AREA_RST);
    write_reg(wtls_pkg::REG_INFLOW_GAIN, '0);
    send_sample(32'h8000_0000, 1'b0);
    wait_idle();
    write_reg(wtls_pkg::REG_INFLOW_GAIN, wtls_pkg::INFLOW_GAIN_RST);
    write_reg(wtls_pkg::REG_PIPE_COEF, '0);
    send_sample(32'h0000_0000, 1'b1);
    wait_idle();
    write_reg(wtls_pkg::REG_PIPE_COEF, wtls_pkg::PIPE_COEF_RST);
    send_sample(32'h0000_0100, 1'b0);
    wait_idle();
  endtask

  task automatic test_level_clamping();
    write_reg(wtls_pkg::REG_BASE_AREA, 32'd1);
    write_reg(wtls_pkg::REG_INFLOW_GAIN, '1);
    write_reg(wtls_pkg::REG_TIME_STEP, '1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    wait_idle();
    write_reg(wtls_pkg::REG_BASE_AREA, wtls_pkg::BASE_AREA_RST);
    write_reg(wtls_pkg::REG_INFLOW_GAIN, wtls_pkg::INFLOW_GAIN_RST);
    write_reg(wtls_pkg::REG_TIME_STEP, wtls_pkg::TIME_STEP_RST);
    write_reg(wtls_pkg::REG_START_LEVEL, '0);
    send_sample(32'h0002_0000, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    wait_idle();
    write_reg(wtls_pkg::REG_DRAIN_FLOW, '1);
    write_reg(wtls_pkg::REG_START_LEVEL, '1);
    send_sample(32'h0000_0000, 1'b1);
    wait_idle();
    write_reg(ADDR_SPARE_LO, '0);
    write_reg(ADDR_SPARE_HI, '1);
    write_reg(wtls_pkg::REG_DRAIN_FLOW, wtls_pkg::DRAIN_FLOW_RST);
    send_sample(32'h0001_0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_operation();
    cfg_profile_e plan[8];
    cfg_profile_e prof;
    int           bad_reg;
    plan = '{PROF_PLANT, PROF_FULL_RANGE, PROF_PLANT, PROF_EXTREME,
             PROF_BAD_PARAM, PROF_PLANT, PROF_FULL_RANGE, PROF_EXTREME};
    for (int phase = 0; phase < 8; phase++) begin
      prof = plan[phase];
      case (prof)
        PROF_FULL_RANGE: begin
          write_reg(wtls_pkg::REG_BASE_AREA, $urandom | 32'd1);
          write_reg(wtls_pkg::REG_DRAIN_FLOW, $urandom);
          write_reg(wtls_pkg::REG_INFLOW_GAIN, $urandom | 32'd1);
          write_reg(wtls_pkg::REG_PIPE_COEF, $urandom | 32'd1);
          write_reg(wtls_pkg::REG_TIME_STEP, $urandom);
          write_reg(wtls_pkg::REG_START_LEVEL, $urandom);
        end
        PROF_EXTREME: begin
          write_reg(wtls_pkg::REG_BASE_AREA, pick_extreme());
          write_reg(wtls_pkg::REG_DRAIN_FLOW, pick_extreme());
          write_reg(wtls_pkg::REG_INFLOW_GAIN, pick_extreme());
          write_reg(wtls_pkg::REG_PIPE_COEF, pick_extreme());
          write_reg(wtls_pkg::REG_TIME_STEP, pick_extreme());
          write_reg(wtls_pkg::REG_START_LEVEL, pick_extreme());
        end
        default: begin
          write_reg(wtls_pkg::REG_BASE_AREA, $urandom_range(1 << 12, 1 << 20));
          write_reg(wtls_pkg::REG_DRAIN_FLOW, $urandom_range(0, 1 << 17));
          write_reg(wtls_pkg::REG_INFLOW_GAIN, $urandom_range(1 << 12, 1 << 18));
          write_reg(wtls_pkg::REG_PIPE_COEF, $urandom_range(1 << 10, 1 << 17));
          write_reg(wtls_pkg::REG_TIME_STEP, $urandom_range(1, 1 << 17));
          write_reg(wtls_pkg::REG_START_LEVEL, $urandom_range(0, 1 << 24));
          if (prof == PROF_BAD_PARAM) begin
            bad_reg = $urandom_range(2);
            case (bad_reg)
              0:       write_reg(wtls_pkg::REG_BASE_AREA, '0);
              1:       write_reg(wtls_pkg::REG_INFLOW_GAIN, '0);
              default: write_reg(wtls_pkg::REG_PIPE_COEF, '0);
            endcase
          end
        end
      endcase
      gaps_on = (phase % 3) != 0;
      burst_left = 0;
      case (phase % 4)
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        2:       stall_pct = 70;
        default: stall_pct = 10;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_inflow(), $urandom_range(99) < 8);
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_registers();
    stall_pct = 40;
    gaps_on = 1'b1;
    test_invalid_parameters();
    stall_pct = 0;
    gaps_on = 1'b0;
    test_level_clamping();
    test_random_operation();
    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* water_tank_level_step_core.f */
sv/wtls_pkg.sv
sv/water_tank_level_step_core.sv
sv/wtls_checker.sv
tb/water_tank_level_step_core_tb.sv
